### hw/rtl/klhc_pkg.sv
package klhc_pkg;

    localparam int KEY_WORD_BITS    = 64;
    localparam int KEY_BITS         = 4 * KEY_WORD_BITS;
    localparam int TIME_BITS        = 48;
    localparam int AGE_BITS         = TIME_BITS + 1;
    localparam int HANDLE_PORT_BITS = 32;
    localparam int OCC_BITS         = 7;

    localparam int ENTRIES_DEF      = 4;
    localparam int HANDLE_BITS_DEF  = 32;

    typedef enum logic [1:0] {
        OP_LOOKUP    = 2'd0,
        OP_STORE     = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_OCCUPANCY = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

### hw/rtl/keyed_lru_handle_cache_unit.sv
// A lookup or store goes from ST_IDLE to ST_SCAN, which checks every entry, and then to
// ST_DONE; clear and occupancy reads go from ST_IDLE straight to ST_DONE.
// One item at a time: o_stall is high outside ST_IDLE; ST_DONE waits for a free output
// register, and the scan reads one entry per cycle from the key and metadata memories.
// Reset (synchronous, active low) clears the valid bits, the entry count and both
// handshakes; the memories keep their contents and need no clearing pass.
module keyed_lru_handle_cache_unit #(
    parameter int ENTRIES     = klhc_pkg::ENTRIES_DEF,
    parameter int HANDLE_BITS = klhc_pkg::HANDLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  klhc_pkg::t_op                          i_operation,
    input  logic [klhc_pkg::KEY_WORD_BITS-1:0]     i_key_word0,
    input  logic [klhc_pkg::KEY_WORD_BITS-1:0]     i_key_word1,
    input  logic [klhc_pkg::KEY_WORD_BITS-1:0]     i_key_word2,
    input  logic [klhc_pkg::KEY_WORD_BITS-1:0]     i_key_word3,
    input  logic [klhc_pkg::HANDLE_PORT_BITS-1:0]  i_data_handle,
    input  logic [klhc_pkg::TIME_BITS-1:0]         i_time_now,

    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_hit,
    output logic [klhc_pkg::HANDLE_PORT_BITS-1:0]  o_found_handle,
    output logic signed [klhc_pkg::AGE_BITS-1:0]   o_age_ms,
    output logic                                   o_evicted,
    output logic [klhc_pkg::OCC_BITS-1:0]          o_occupancy
);
    import klhc_pkg::*;

    localparam int IDXW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW   = $clog2(ENTRIES + 1);
    localparam int META_W = HANDLE_BITS + 2 * TIME_BITS;

    // Memories: key per entry, and {handle, build time, access time} per entry.
    logic [KEY_BITS-1:0] key_mem  [ENTRIES];
    logic [META_W-1:0]   meta_mem [ENTRIES];

    t_state r_state, n_state;

    // Captured item.
    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [TIME_BITS-1:0]  r_time;

    // Table control state.
    logic [ENTRIES-1:0]    r_valid;
    logic [CNTW-1:0]       r_count;

    // Scan state.
    logic [CNTW-1:0]       r_issue_cnt;
    logic                  r_chk_v;
    logic [IDXW-1:0]       r_chk_idx;
    logic [KEY_BITS-1:0]   r_key_q;
    logic [META_W-1:0]     r_meta_q;

    logic                  r_match;
    logic [IDXW-1:0]       r_match_idx;
    logic [HANDLE_BITS-1:0] r_match_handle;
    logic [TIME_BITS-1:0]  r_match_build;
    logic                  r_free_found;
    logic [IDXW-1:0]       r_free_idx;
    logic                  r_victim_found;
    logic [IDXW-1:0]       r_victim_idx;
    logic [TIME_BITS-1:0]  r_vt;
    logic [KEY_BITS-1:0]   r_vk;

    // Output register.
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [HANDLE_PORT_BITS-1:0] r_out_handle;
    logic [AGE_BITS-1:0]   r_out_age;
    logic                  r_out_evicted;
    logic [OCC_BITS-1:0]   r_out_occ;

    logic                  in_take;
    logic                  out_free;
    logic                  rd_en;
    logic [IDXW-1:0]       rd_addr;
    logic                  chk_entry_valid;
    logic [TIME_BITS-1:0]  chk_access;
    logic [TIME_BITS-1:0]  chk_build;
    logic [HANDLE_BITS-1:0] chk_handle;
    logic                  chk_key_eq;
    logic                  chk_older;
    logic                  chk_last;

    logic                  finish;
    logic                  wr_en;
    logic [IDXW-1:0]       wr_addr;
    logic [META_W-1:0]     wr_meta;
    logic                  wr_key_en;
    logic [ENTRIES-1:0]    n_valid;
    logic [CNTW-1:0]       n_count;
    logic                  n_hit;
    logic                  n_evicted;

    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);

    // Scan read side: one entry address per cycle until all have been issued.
    assign rd_en   = (r_state == ST_SCAN) && (r_issue_cnt < CNTW'(ENTRIES));
    assign rd_addr = r_issue_cnt[IDXW-1:0];

    assign chk_entry_valid = r_valid[r_chk_idx];
    assign chk_access      = r_meta_q[TIME_BITS-1:0];
    assign chk_build       = r_meta_q[2*TIME_BITS-1:TIME_BITS];
    assign chk_handle      = r_meta_q[META_W-1:2*TIME_BITS];
    assign chk_key_eq      = (r_key_q == r_key);
    // The key vector puts word0 on top, so a plain compare gives the key order.
    assign chk_older       = (chk_access < r_vt) || ((chk_access == r_vt) && (r_key_q < r_vk));
    assign chk_last        = r_chk_v && (r_chk_idx == IDXW'(ENTRIES - 1));

    assign finish = (r_state == ST_DONE) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (i_operation == OP_LOOKUP || i_operation == OP_STORE) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (chk_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Write-back and result of the finished item.
    always_comb begin
        wr_en     = 1'b0;
        wr_key_en = 1'b0;
        wr_addr   = r_match_idx;
        wr_meta   = {r_handle, r_time, r_time};
        n_valid   = r_valid;
        n_count   = r_count;
        n_hit     = 1'b0;
        n_evicted = 1'b0;
        unique case (r_op)
            OP_LOOKUP: begin
                n_hit   = r_match;
                wr_en   = r_match;
                wr_meta = {r_match_handle, r_match_build, r_time};
            end
            OP_STORE: begin
                priority if (r_match) begin
                    wr_en     = 1'b1;
                    wr_key_en = 1'b1;
                end else if (r_free_found) begin
                    wr_en     = 1'b1;
                    wr_key_en = 1'b1;
                    wr_addr   = r_free_idx;
                    n_valid[r_free_idx] = 1'b1;
                    n_count   = r_count + 1'b1;
                end else begin
                    // Full table: the oldest stored entry is replaced, unless the
                    // new item itself is the oldest, in which case it is dropped.
                    n_evicted = 1'b1;
                    wr_en     = r_victim_found;
                    wr_key_en = r_victim_found;
                    wr_addr   = r_victim_idx;
                end
            end
            OP_CLEAR: begin
                n_valid = '0;
                n_count = '0;
            end
            OP_OCCUPANCY: begin
            end
            default: begin
            end
        endcase
    end

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_key_q  <= key_mem[rd_addr];
            r_meta_q <= meta_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish && wr_key_en) begin
            key_mem[wr_addr] <= r_key;
        end
        if (finish && wr_en) begin
            meta_mem[wr_addr] <= wr_meta;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk_v <= rd_en;
            if (finish) begin
                r_valid     <= n_valid;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op           <= i_operation;
            r_key          <= {i_key_word0, i_key_word1, i_key_word2, i_key_word3};
            r_handle       <= HANDLE_BITS'(i_data_handle);
            r_time         <= i_time_now;
            r_vt           <= i_time_now;
            r_vk           <= {i_key_word0, i_key_word1, i_key_word2, i_key_word3};
            r_issue_cnt    <= '0;
            r_match        <= 1'b0;
            r_free_found   <= 1'b0;
            r_victim_found <= 1'b0;
        end else begin
            if (rd_en) begin
                r_issue_cnt <= r_issue_cnt + 1'b1;
                r_chk_idx   <= rd_addr;
            end
            if (r_chk_v) begin
                if (chk_entry_valid && chk_key_eq && !r_match) begin
                    r_match        <= 1'b1;
                    r_match_idx    <= r_chk_idx;
                    r_match_handle <= chk_handle;
                    r_match_build  <= chk_build;
                end
                if (!chk_entry_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_chk_idx;
                end
                if (chk_entry_valid && chk_older) begin
                    r_victim_found <= 1'b1;
                    r_victim_idx   <= r_chk_idx;
                    r_vt           <= chk_access;
                    r_vk           <= r_key_q;
                end
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_hit     <= n_hit;
            r_out_evicted <= n_evicted;
            r_out_occ     <= OCC_BITS'(n_count);
            if (n_hit) begin
                r_out_handle <= HANDLE_PORT_BITS'(r_match_handle);
                r_out_age    <= AGE_BITS'(r_time) - AGE_BITS'(r_match_build);
            end else begin
                r_out_handle <= '0;
                r_out_age    <= '0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_found_handle = r_out_handle;
    assign o_age_ms       = $signed(r_out_age);
    assign o_evicted      = r_out_evicted;
    assign o_occupancy    = r_out_occ;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("entry count differs from the number of valid entries");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ENTRIES)
        else $error("entry count exceeds the table size");

    a_evict_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evicted) |-> (32'(o_occupancy) == ENTRIES))
        else $error("eviction reported while the table was not full");

    a_hit_without_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted))
        else $error("hit and eviction reported for the same item");

    a_check_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_v |-> (r_state == ST_SCAN))
        else $error("scan data checked outside the scan");
`endif

endmodule
